### sv/rcce_pkg.sv
// Shared types and constants for the RGB convolution block.
`timescale 1ns / 1ps

package rcce_pkg;

    // Command codes carried by an input transaction
    typedef enum logic [1:0] {
        CMD_COEF    = 2'd0,
        CMD_STORE   = 2'd1,
        CMD_COMPUTE = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_WAIT
    } state_t;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_NUM_ROWS     = 2'd0;
    localparam logic [1:0] REG_NUM_COLS     = 2'd1;
    localparam logic [1:0] REG_FILTER_WIDTH = 2'd2;

    localparam int CFG_AW    = 4;
    localparam int CFG_DW    = 32;
    localparam int DIM_W     = 9;
    localparam int FW_W      = 4;
    localparam int POS_W     = 8;
    localparam int POS_DEPTH = 256;
    localparam int CIDX_W    = 7;
    localparam int COEF_W    = 16;
    localparam int CH_W      = 8;
    localparam int PROD_W    = COEF_W + CH_W + 1;
    localparam int FRAC_BITS = 14;

    localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'd255;
    localparam logic [CH_W-1:0] CH_MAX       = 8'd255;

    // One pixel, red in the low byte
    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } rgb_t;

    // Control from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic clear;
        logic tap_vld;
        logic tap_last;
    } mac_ctl_t;

endpackage

### sv/rcce_if.sv
// Valid/ready channel interfaces for command input and filtered pixel output.
`timescale 1ns / 1ps

interface rcce_req_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 cmd;
    logic [7:0]                 row;
    logic [7:0]                 col;
    logic [6:0]                 coef_index;
    logic signed [15:0]         coef_value;
    logic [7:0]                 red_in;
    logic [7:0]                 green_in;
    logic [7:0]                 blue_in;

    modport source (
        output valid, cmd, row, col, coef_index, coef_value, red_in, green_in, blue_in,
        input  ready
    );
    modport sink (
        input  valid, cmd, row, col, coef_index, coef_value, red_in, green_in, blue_in,
        output ready
    );
endinterface

interface rcce_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;

    modport source (
        output valid, red_out, green_out, blue_out, alpha_out,
        input  ready
    );
    modport sink (
        input  valid, red_out, green_out, blue_out, alpha_out,
        output ready
    );
endinterface

### sv/rcce_mac.sv
// Shared multiply-accumulate unit: three channel products per tap, then saturation.
`timescale 1ns / 1ps

module rcce_mac #(
    parameter int ACC_W = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  rcce_pkg::mac_ctl_t                ctl,
    input  logic signed [rcce_pkg::COEF_W-1:0] coef,
    input  rcce_pkg::rgb_t                    pix,
    output logic                              done,
    output rcce_pkg::rgb_t                    res
);
    import rcce_pkg::*;

    logic signed [PROD_W-1:0] prod_reg [3];
    logic signed [PROD_W-1:0] prod_next [3];
    logic signed [ACC_W-1:0]  acc_reg [3];
    logic signed [ACC_W-1:0]  acc_next [3];
    logic                     prod_vld_reg, prod_vld_next;
    logic                     prod_last_reg, prod_last_next;
    logic                     done_reg, done_next;
    logic [CH_W-1:0]          chan [3];
    logic [CH_W-1:0]          sat [3];
    logic [ACC_W-1:0]         quot [3];

    assign chan[0] = pix.red;
    assign chan[1] = pix.green;
    assign chan[2] = pix.blue;

    // Multiply each channel by the tap weight
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            prod_next[i] = PROD_W'(coef * $signed({1'b0, chan[i]}));
        end
        prod_vld_next  = ctl.tap_vld;
        prod_last_next = ctl.tap_vld & ctl.tap_last;
    end

    // Accumulate products; clear at the start of a compute
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (ctl.clear)
                acc_next[i] = '0;
            else if (prod_vld_reg)
                acc_next[i] = acc_reg[i] + {{(ACC_W-PROD_W){prod_reg[i][PROD_W-1]}}, prod_reg[i]};
            else
                acc_next[i] = acc_reg[i];
        end
        done_next = prod_vld_reg & prod_last_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            prod_reg[i] <= prod_next[i];
            acc_reg[i]  <= acc_next[i];
        end
        prod_last_reg <= prod_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= prod_vld_next;
            done_reg     <= done_next;
        end
    end

    // Drop the fraction and saturate each channel to 0..255
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            quot[i] = ACC_W'(acc_reg[i] >>> FRAC_BITS);
            if (acc_reg[i] <= 0)
                sat[i] = '0;
            else if (quot[i] > ACC_W'(CH_MAX))
                sat[i] = CH_MAX;
            else
                sat[i] = quot[i][CH_W-1:0];
        end
    end

    assign res.red   = sat[0];
    assign res.green = sat[1];
    assign res.blue  = sat[2];
    assign done      = done_reg;

endmodule

### sv/rgb_convolution_clamp_edge.sv
// Top level: RGB convolution with clamp-to-edge taps, frame store and coefficient table.
`timescale 1ns / 1ps

// Usage
// req carries one command per transaction: write a filter coefficient, store an RGB
// pixel at (row, col), or compute the filtered pixel at (row, col). rsp returns one
// transaction per compute with the three saturated channels and alpha fixed at 255.
// Coefficient and store commands return nothing.
// A compute walks the w x w taps (w the effective filter width) one tap per cycle,
// each tap costing one frame store read, all three channels multiplied in parallel
// in one shared multiply-accumulate unit. req.ready is low from the accepted compute
// until its result is loaded into the output register; the result becomes valid as
// req.ready returns, so a new command is taken only once that compute is done.
// Configuration is written over the APB port while the block is idle.
// Reset clears the sequencer, the coefficient table (all taps read as zero) and the
// registers to 256 rows, 256 columns and filter width 1. The frame store holds
// nothing until written; no clearing pass is run.
// A result waiting on a stalled receiver sits in the output register. Coefficient
// and store commands are still taken meanwhile; a compute runs and holds its sum
// until the output register frees.

module rgb_convolution_clamp_edge #(
    parameter int MAX_ROWS         = 256,
    parameter int MAX_COLS         = 256,
    parameter int MAX_FILTER_WIDTH = 9
) (
    input  logic                        clk,
    input  logic                        rst_n,
    rcce_req_if.sink                    req,
    rcce_rsp_if.source                  rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rcce_pkg::CFG_AW-1:0] paddr,
    input  logic [rcce_pkg::CFG_DW-1:0] pwdata,
    output logic [rcce_pkg::CFG_DW-1:0] prdata,
    output logic                        pready
);
    import rcce_pkg::*;

    localparam int ROW_DEPTH = (MAX_ROWS < POS_DEPTH) ? MAX_ROWS : POS_DEPTH;
    localparam int COL_DEPTH = (MAX_COLS < POS_DEPTH) ? MAX_COLS : POS_DEPTH;
    localparam int RB        = (ROW_DEPTH > 1) ? $clog2(ROW_DEPTH) : 1;
    localparam int CB        = (COL_DEPTH > 1) ? $clog2(COL_DEPTH) : 1;
    localparam int FS_DEPTH  = 1 << (RB + CB);
    localparam int TAP_DEPTH = MAX_FILTER_WIDTH * MAX_FILTER_WIDTH;
    localparam int KB        = (TAP_DEPTH > 1) ? $clog2(TAP_DEPTH) : 1;
    localparam int IDX_W     = (KB > CIDX_W) ? KB : CIDX_W;
    localparam int ACC_W     = PROD_W + $clog2(TAP_DEPTH + 1);
    localparam int LIM_W     = 13;
    localparam int TP_W      = 11;

    localparam logic [LIM_W-1:0] ROW_LIM = LIM_W'(MAX_ROWS);
    localparam logic [LIM_W-1:0] COL_LIM = LIM_W'(MAX_COLS);
    localparam logic [FW_W-1:0]  FW_LIM  = FW_W'(MAX_FILTER_WIDTH);
    localparam logic [IDX_W-1:0] TAP_LIM = IDX_W'(TAP_DEPTH);

    // Configuration registers
    logic [DIM_W-1:0] num_rows_reg, num_rows_next;
    logic [DIM_W-1:0] num_cols_reg, num_cols_next;
    logic [FW_W-1:0]  fw_reg, fw_next;
    logic             cfg_we;

    // Sequencer
    state_t           state_reg, state_next;
    logic [POS_W-1:0] row_reg, row_next;
    logic [POS_W-1:0] col_reg, col_next;
    logic [FW_W-1:0]  dr_reg, dr_next;
    logic [FW_W-1:0]  dc_reg, dc_next;
    logic [KB-1:0]    kidx_reg, kidx_next;
    logic             acc_done_reg, acc_done_next;
    logic             rsp_vld_reg, rsp_vld_next;
    rgb_t             rsp_data_reg, rsp_data_next;

    // Read pipeline
    logic             rd_vld_reg, rd_last_reg;
    rgb_t             pix_rd_reg;
    logic [COEF_W-1:0] coef_rd_reg;
    logic             coef_hit_reg;
    logic [TAP_DEPTH-1:0] coef_valid_reg, coef_valid_next;

    // Storage
    rgb_t             fs_mem [FS_DEPTH];
    logic [COEF_W-1:0] coef_mem [TAP_DEPTH];

    // Combinational control
    logic             in_take, take_coef, take_store, take_compute;
    logic             issue, tap_last, load, done_any;
    logic [DIM_W-1:0] nr, nc, row_hi, col_hi;
    logic [FW_W-1:0]  fw_sat, w_eff, half;
    logic [DIM_W-1:0] tap_row, tap_col;
    logic [IDX_W-1:0] cidx;
    logic             coef_we, fs_we;
    logic [RB+CB-1:0] fs_waddr, fs_raddr;
    mac_ctl_t         mac_ctl;
    logic             mac_done;
    rgb_t             mac_res;
    logic signed [COEF_W-1:0] coef_use;

    // Clamp a center coordinate plus tap offset into 0..hi
    function automatic logic [DIM_W-1:0] clamp_tap(
        input logic [POS_W-1:0] ctr,
        input logic [FW_W-1:0]  off,
        input logic [FW_W-1:0]  hlf,
        input logic [DIM_W-1:0] hi
    );
        logic signed [TP_W-1:0] p;
        logic [DIM_W-1:0]       q;
        p = $signed({3'b0, ctr}) + $signed({7'b0, off}) - $signed({7'b0, hlf});
        if (p < 0)
            q = '0;
        else if (p > $signed({2'b0, hi}))
            q = hi;
        else
            q = p[DIM_W-1:0];
        return q;
    endfunction

    // APB register port
    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite;

    always_comb
    begin
        num_rows_next = num_rows_reg;
        num_cols_next = num_cols_reg;
        fw_next       = fw_reg;
        if (cfg_we)
        begin
            unique case (paddr[3:2])
                REG_NUM_ROWS:     num_rows_next = pwdata[DIM_W-1:0];
                REG_NUM_COLS:     num_cols_next = pwdata[DIM_W-1:0];
                REG_FILTER_WIDTH: fw_next       = pwdata[FW_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_NUM_ROWS:     prdata = CFG_DW'(num_rows_reg);
            REG_NUM_COLS:     prdata = CFG_DW'(num_cols_reg);
            REG_FILTER_WIDTH: prdata = CFG_DW'(fw_reg);
            default:          prdata = '0;
        endcase
    end

    // Effective image size and filter width
    always_comb
    begin
        if (num_rows_reg == '0)
            nr = DIM_W'(1);
        else if ({4'b0, num_rows_reg} > ROW_LIM)
            nr = DIM_W'(MAX_ROWS);
        else
            nr = num_rows_reg;

        if (num_cols_reg == '0)
            nc = DIM_W'(1);
        else if ({4'b0, num_cols_reg} > COL_LIM)
            nc = DIM_W'(MAX_COLS);
        else
            nc = num_cols_reg;

        fw_sat = (fw_reg > FW_LIM) ? FW_LIM : fw_reg;
        if (fw_sat == '0)
            w_eff = FW_W'(1);
        else if (!fw_sat[0])
            w_eff = fw_sat - FW_W'(1);
        else
            w_eff = fw_sat;
        half   = w_eff >> 1;
        row_hi = nr - DIM_W'(1);
        col_hi = nc - DIM_W'(1);
    end

    // Decode the accepted command
    assign in_take      = req.valid & req.ready;
    assign take_coef    = in_take & (req.cmd == CMD_COEF);
    assign take_store   = in_take & (req.cmd == CMD_STORE);
    assign take_compute = in_take & (req.cmd == CMD_COMPUTE);

    assign tap_last = (dr_reg == w_eff - FW_W'(1)) && (dc_reg == w_eff - FW_W'(1));
    assign done_any = mac_done | acc_done_reg;
    assign load     = done_any & (~rsp_vld_reg | rsp.ready);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (take_compute) state_next = ST_RUN;
            ST_RUN:  if (tap_last)     state_next = ST_WAIT;
            ST_WAIT: if (load)         state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb
    begin
        req.ready = 1'b0;
        issue     = 1'b0;
        unique case (state_reg)
            ST_IDLE: req.ready = 1'b1;
            ST_RUN:  issue     = 1'b1;
            ST_WAIT: ;
            default: ;
        endcase
    end

    // Tap counters and latched center
    always_comb
    begin
        row_next  = row_reg;
        col_next  = col_reg;
        dr_next   = dr_reg;
        dc_next   = dc_reg;
        kidx_next = kidx_reg;
        if (take_compute)
        begin
            row_next  = req.row;
            col_next  = req.col;
            dr_next   = '0;
            dc_next   = '0;
            kidx_next = '0;
        end
        else if (issue)
        begin
            kidx_next = kidx_reg + KB'(1);
            if (dc_reg == w_eff - FW_W'(1))
            begin
                dc_next = '0;
                dr_next = dr_reg + FW_W'(1);
            end
            else
            begin
                dc_next = dc_reg + FW_W'(1);
            end
        end
    end

    // Hold the finished sum until the output register frees, then load it
    always_comb
    begin
        acc_done_next = done_any & ~load;
        rsp_data_next = load ? mac_res : rsp_data_reg;
        if (load)
            rsp_vld_next = 1'b1;
        else if (rsp.ready)
            rsp_vld_next = 1'b0;
        else
            rsp_vld_next = rsp_vld_reg;
    end

    // Memory addresses and write enables
    assign tap_row  = clamp_tap(row_reg, dr_reg, half, row_hi);
    assign tap_col  = clamp_tap(col_reg, dc_reg, half, col_hi);
    assign fs_raddr = {tap_row[RB-1:0], tap_col[CB-1:0]};
    assign fs_waddr = {req.row[RB-1:0], req.col[CB-1:0]};
    assign fs_we    = take_store & ({5'b0, req.row} < ROW_LIM) & ({5'b0, req.col} < COL_LIM);
    assign cidx     = IDX_W'(req.coef_index);
    assign coef_we  = take_coef & (cidx < TAP_LIM);

    always_comb
    begin
        coef_valid_next = coef_valid_reg;
        if (coef_we)
            coef_valid_next[cidx[KB-1:0]] = 1'b1;
    end

    // Frame store
    always_ff @(posedge clk)
    begin
        if (fs_we)
            fs_mem[fs_waddr] <= '{blue: req.blue_in, green: req.green_in, red: req.red_in};
        pix_rd_reg <= fs_mem[fs_raddr];
    end

    // Coefficient table
    always_ff @(posedge clk)
    begin
        if (coef_we)
            coef_mem[cidx[KB-1:0]] <= req.coef_value;
        coef_rd_reg <= coef_mem[kidx_reg];
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg   <= DIM_W'(256);
            num_cols_reg   <= DIM_W'(256);
            fw_reg         <= FW_W'(1);
            state_reg      <= ST_IDLE;
            acc_done_reg   <= 1'b0;
            rsp_vld_reg    <= 1'b0;
            rd_vld_reg     <= 1'b0;
            coef_valid_reg <= '0;
        end
        else
        begin
            num_rows_reg   <= num_rows_next;
            num_cols_reg   <= num_cols_next;
            fw_reg         <= fw_next;
            state_reg      <= state_next;
            acc_done_reg   <= acc_done_next;
            rsp_vld_reg    <= rsp_vld_next;
            rd_vld_reg     <= issue;
            coef_valid_reg <= coef_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        row_reg      <= row_next;
        col_reg      <= col_next;
        dr_reg       <= dr_next;
        dc_reg       <= dc_next;
        kidx_reg     <= kidx_next;
        rd_last_reg  <= tap_last;
        coef_hit_reg <= coef_valid_reg[kidx_reg];
        rsp_data_reg <= rsp_data_next;
    end

    // Shared multiply-accumulate unit
    assign coef_use         = coef_hit_reg ? $signed(coef_rd_reg) : '0;
    assign mac_ctl.clear    = take_compute;
    assign mac_ctl.tap_vld  = rd_vld_reg;
    assign mac_ctl.tap_last = rd_last_reg;

    rcce_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .coef  (coef_use),
        .pix   (pix_rd_reg),
        .done  (mac_done),
        .res   (mac_res)
    );

    // Result channel
    assign rsp.valid     = rsp_vld_reg;
    assign rsp.red_out   = rsp_data_reg.red;
    assign rsp.green_out = rsp_data_reg.green;
    assign rsp.blue_out  = rsp_data_reg.blue;
    assign rsp.alpha_out = ALPHA_OPAQUE;

endmodule

### sv/rcce_chk.sv
// Port-level checker for the RGB convolution block, bound to the top level.
`timescale 1ns / 1ps

module rcce_chk (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic [1:0] req_cmd,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [7:0] red_out,
    input logic [7:0] green_out,
    input logic [7:0] blue_out,
    input logic [7:0] alpha_out
);
    import rcce_pkg::*;

    // A stalled result holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(red_out) && $stable(green_out)
            && $stable(blue_out))
        else $error("stalled result changed");

    // Every result is opaque
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> alpha_out == ALPHA_OPAQUE)
        else $error("alpha not opaque");

    // A compute blocks further commands while the taps are walked
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_cmd == CMD_COMPUTE |=> !req_ready)
        else $error("command taken during compute");

    // A new result appears only at the end of a compute
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> !$past(req_ready))
        else $error("result without compute");

    // Coefficient and store commands return nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_cmd == CMD_COEF || req_cmd == CMD_STORE)
            |=> !$rose(rsp_valid))
        else $error("result after non-compute command");

endmodule

bind rgb_convolution_clamp_edge rcce_chk u_rcce_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .req_cmd   (req.cmd),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .red_out   (rsp.red_out),
    .green_out (rsp.green_out),
    .blue_out  (rsp.blue_out),
    .alpha_out (rsp.alpha_out)
);

### tb/rgb_convolution_clamp_edge_tb.sv
// Testbench for the RGB clamp-to-edge convolution block: directed cases and random traffic.
`timescale 1ns / 1ps

module rgb_convolution_clamp_edge_tb;
    import rcce_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 10;
    localparam int MAX_FW        = 9;
    localparam int TAP_COUNT     = MAX_FW * MAX_FW;
    localparam int FRAME_DEPTH   = POS_DEPTH * POS_DEPTH;
    localparam int RANDOM_ITEMS  = 1500;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 100;
    localparam int TIMEOUT_NS    = 40_000_000;

    // One command transaction as the sender builds it
    typedef struct packed {
        cmd_t              cmd;
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
        logic [CIDX_W-1:0] coef_index;
        logic [COEF_W-1:0] coef_value;
        rgb_t              color;
    } command_t;

    // One filtered pixel as the block returns it
    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] alpha;
    } pixel_out_t;

    logic              clk   = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [CFG_DW-1:0] pwdata;
    logic [CFG_DW-1:0] prdata;
    logic              pready;

    rcce_req_if req_ch ();
    rcce_rsp_if rsp_ch ();

    rgb_convolution_clamp_edge dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow of the block: frame store, coefficient table and registers
    rgb_t                     frame_mem   [0:FRAME_DEPTH-1];
    bit                       pixel_known [0:FRAME_DEPTH-1];
    logic signed [COEF_W-1:0] tap_table   [0:TAP_COUNT-1];
    logic [DIM_W-1:0]         cfg_rows;
    logic [DIM_W-1:0]         cfg_cols;
    logic [FW_W-1:0]          cfg_width;
    pixel_out_t               pending_pixels [$];
    pixel_out_t               oldest;

    int useful_items   = 0;
    int pixels_checked = 0;
    int stores_sent    = 0;
    int taps_sent      = 0;
    int reg_writes     = 0;
    int mismatches     = 0;
    int hold_requests  = 0;
    int holds_done     = 0;
    int stall_left     = 0;
    int mode_left      = 0;
    bit rsp_steady     = 1'b0;
    bit steady_sender  = 1'b0;

    always
    begin
        #(HALF_PERIOD) clk = 1'b1;
        #(HALF_PERIOD) clk = 1'b0;
    end

    // Idle length: mostly short, now and then a long pause
    function automatic int idle_len();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(12, 50);
    endfunction

    function automatic int active_dim(input logic [DIM_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > POS_DEPTH)
            return POS_DEPTH;
        return v;
    endfunction

    // Oversized widths saturate, then an even width drops by one (zero acts as one)
    function automatic int active_width();
        int w;
        w = cfg_width;
        if (w > MAX_FW)
            w = MAX_FW;
        if (w % 2 == 0)
            w = (w == 0) ? 1 : w - 1;
        return w;
    endfunction

    // Frame store address of one tap, clamped into the image in use
    function automatic int tap_addr(input logic [POS_W-1:0] row, input logic [POS_W-1:0] col,
                                    input int dr, input int dc);
        int r;
        int c;
        int nr;
        int nc;
        nr = active_dim(cfg_rows);
        nc = active_dim(cfg_cols);
        r  = row;
        c  = col;
        r  = r + dr;
        c  = c + dc;
        if (r < 0)
            r = 0;
        if (r > nr - 1)
            r = nr - 1;
        if (c < 0)
            c = 0;
        if (c > nc - 1)
            c = nc - 1;
        return r * POS_DEPTH + c;
    endfunction

    // Drop the fraction, then saturate to one channel
    function automatic logic [CH_W-1:0] saturate_channel(input int acc);
        int q;
        if (acc <= 0)
            return '0;
        q = acc >>> FRAC_BITS;
        if (q > int'(CH_MAX))
            return CH_MAX;
        return q[CH_W-1:0];
    endfunction

    // Filtered pixel at (row, col) from the shadow state
    function automatic pixel_out_t filter_at(input logic [POS_W-1:0] row,
                                             input logic [POS_W-1:0] col);
        int         w;
        int         h;
        int         k;
        int         acc_r;
        int         acc_g;
        int         acc_b;
        rgb_t       p;
        pixel_out_t res;
        w     = active_width();
        h     = w / 2;
        acc_r = 0;
        acc_g = 0;
        acc_b = 0;
        for (int dr = -h; dr <= h; dr++)
        begin
            for (int dc = -h; dc <= h; dc++)
            begin
                p     = frame_mem[tap_addr(row, col, dr, dc)];
                k     = tap_table[(dr + h) * w + dc + h];
                acc_r = acc_r + k * int'(p.red);
                acc_g = acc_g + k * int'(p.green);
                acc_b = acc_b + k * int'(p.blue);
            end
        end
        res.red   = saturate_channel(acc_r);
        res.green = saturate_channel(acc_g);
        res.blue  = saturate_channel(acc_b);
        res.alpha = ALPHA_OPAQUE;
        return res;
    endfunction

    // Update the shadow state for one accepted transaction
    function automatic void apply_command(input command_t c);
        case (c.cmd)
            CMD_COEF:
                if (c.coef_index < TAP_COUNT)
                begin
                    tap_table[c.coef_index] = c.coef_value;
                    taps_sent++;
                    useful_items++;
                end
            CMD_STORE:
            begin
                frame_mem[{c.row, c.col}]   = c.color;
                pixel_known[{c.row, c.col}] = 1'b1;
                stores_sent++;
                useful_items++;
            end
            CMD_COMPUTE:
            begin
                pending_pixels.push_back(filter_at(c.row, c.col));
                useful_items++;
            end
            default:
                ;
        endcase
    endfunction

    // Every field random; callers overwrite what matters
    function automatic command_t noise_command();
        command_t    c;
        logic [31:0] a;
        logic [31:0] b;
        a            = $urandom();
        b            = $urandom();
        c.cmd        = cmd_t'(a[1:0]);
        c.row        = a[9:2];
        c.col        = a[17:10];
        c.coef_index = a[24:18];
        c.coef_value = b[15:0];
        c.color      = {b[31:16], a[31:24]};
        return c;
    endfunction

    // Mostly modest weights so that sums land inside 0..255, some full range
    function automatic logic [COEF_W-1:0] pick_coef(input int w);
        int          span;
        int          r;
        int          v;
        logic [31:0] raw;
        span = 16384 / (w * w);
        r    = $urandom_range(0, 9);
        if (r == 0)
            return ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
        if (r < 3)
        begin
            raw = $urandom();
            return raw[15:0];
        end
        v = $urandom_range(0, 3 * span);
        v = v - span;
        return v[15:0];
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return 9'd1;
            2:       return 9'd256;
            3:       return 9'($urandom_range(257, 511));
            4:       return 9'($urandom_range(1, 256));
            default: return 9'($urandom_range(2, 12));
        endcase
    endfunction

    function automatic logic [FW_W-1:0] pick_width();
        case ($urandom_range(0, 9))
            0:       return 4'($urandom_range(0, 15));
            1:       return 4'd9;
            2:       return 4'd7;
            default: return 4'($urandom_range(1, 5));
        endcase
    endfunction

    // Offer one transaction, hold it until taken, then advance the shadow state.
    // Called and returns at a rising edge.
    task automatic send_command(input command_t c);
        bit taken;
        int gap;
        gap = 0;
        if (!steady_sender && $urandom_range(0, 2) == 0)
            gap = idle_len();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.cmd        <= c.cmd;
        req_ch.row        <= c.row;
        req_ch.col        <= c.col;
        req_ch.coef_index <= c.coef_index;
        req_ch.coef_value <= c.coef_value;
        req_ch.red_in     <= c.color.red;
        req_ch.green_in   <= c.color.green;
        req_ch.blue_in    <= c.color.blue;
        req_ch.valid      <= 1'b1;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = req_ch.ready;
            @(posedge clk);
        end
        apply_command(c);
    endtask

    task automatic write_tap(input int idx, input logic [COEF_W-1:0] value);
        command_t c;
        c            = noise_command();
        c.cmd        = CMD_COEF;
        c.coef_index = idx[CIDX_W-1:0];
        c.coef_value = value;
        send_command(c);
    endtask

    task automatic store_at(input logic [POS_W-1:0] row, input logic [POS_W-1:0] col,
                            input logic [23:0] color);
        command_t c;
        c       = noise_command();
        c.cmd   = CMD_STORE;
        c.row   = row;
        c.col   = col;
        c.color = color;
        send_command(c);
    endtask

    // Store any tap pixel not yet written, then ask for the filtered pixel
    task automatic compute_at(input logic [POS_W-1:0] row, input logic [POS_W-1:0] col);
        command_t    c;
        int          h;
        int          a;
        logic [31:0] raw;
        h = active_width() / 2;
        for (int dr = -h; dr <= h; dr++)
        begin
            for (int dc = -h; dc <= h; dc++)
            begin
                a = tap_addr(row, col, dr, dc);
                if (!pixel_known[a])
                begin
                    raw = $urandom();
                    store_at(a[15:8], a[7:0], raw[23:0]);
                end
            end
        end
        c     = noise_command();
        c.cmd = CMD_COMPUTE;
        c.row = row;
        c.col = col;
        send_command(c);
    endtask

    task automatic send_unknown();
        command_t c;
        c     = noise_command();
        c.cmd = CMD_NONE;
        send_command(c);
    endtask

    // Drop valid and wait until every expected pixel is back and the block has settled
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Setup cycle, access cycle, then release the bus
    task automatic write_register(input logic [1:0] idx, input logic [DIM_W-1:0] value);
        bit done;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{(CFG_DW - DIM_W){1'b0}}, value};
        @(posedge clk);
        penable <= 1'b1;
        done = 1'b0;
        while (!done)
        begin
            @(negedge clk);
            done = pready;
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_NUM_ROWS:     cfg_rows  = value;
            REG_NUM_COLS:     cfg_cols  = value;
            REG_FILTER_WIDTH: cfg_width = value[FW_W-1:0];
            default:          ;
        endcase
        reg_writes++;
    endtask

    task automatic set_config(input logic [DIM_W-1:0] rows, input logic [DIM_W-1:0] cols,
                              input logic [FW_W-1:0] width);
        wait_idle();
        write_register(REG_NUM_ROWS, rows);
        write_register(REG_NUM_COLS, cols);
        write_register(REG_FILTER_WIDTH, {5'd0, width});
    endtask

    // Reset registers: full frame, single-tap filter, all taps zero
    task automatic test_reset_defaults();
        store_at(8'd0, 8'd0, 24'h01_80_FF);
        compute_at(8'd0, 8'd0);
        store_at(8'd255, 8'd255, 24'hFF_00_7F);
        write_tap(0, 16'h4000);
        compute_at(8'd0, 8'd0);
        compute_at(8'd255, 8'd255);
        // indexes past the table are dropped
        write_tap(TAP_COUNT, 16'h7FFF);
        write_tap(127, 16'h7FFF);
        send_unknown();
        compute_at(8'd255, 8'd255);
    endtask

    task automatic test_special_cases();
        // even width acts as three on a two by two image
        set_config(9'd2, 9'd2, 4'd4);
        store_at(8'd0, 8'd0, 24'hFF_FF_FF);
        store_at(8'd0, 8'd1, 24'h00_00_00);
        store_at(8'd1, 8'd0, 24'h80_40_C0);
        store_at(8'd1, 8'd1, 24'h32_64_C8);
        // center weight near two: large sums saturate high
        write_tap(4, 16'h7FFF);
        compute_at(8'd1, 8'd1);
        // center outside the image clamps to the last pixel
        compute_at(8'd200, 8'd200);
        // most negative weight: sums saturate at zero
        write_tap(4, 16'h8000);
        compute_at(8'd0, 8'd0);
        // zero rows act as one, oversized columns and width saturate
        set_config(9'd0, 9'd511, 4'd15);
        compute_at(8'd0, 8'd255);
        // zero width acts as one
        set_config(9'd300, 9'd3, 4'd0);
        compute_at(8'd255, 8'd2);
    endtask

    // Stall the output long enough that the block backs up into its input
    task automatic test_output_backpressure();
        logic [31:0] raw;
        set_config(9'd4, 9'd4, 4'd3);
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                raw = $urandom();
                store_at(8'(r), 8'(c), raw[23:0]);
            end
        end
        for (int i = 0; i < 9; i++)
            write_tap(i, pick_coef(3));
        steady_sender = 1'b1;
        hold_requests++;
        repeat (12) compute_at(8'($urandom_range(0, 5)), 8'($urandom_range(0, 5)));
        steady_sender = 1'b0;
    endtask

    // Phases of random settings: load a kernel, then mixed commands
    task automatic test_random_traffic();
        int          start;
        int          w;
        int          nr;
        int          nc;
        int          r;
        logic [31:0] raw;
        start = useful_items;
        while (useful_items - start < RANDOM_ITEMS)
        begin
            set_config(pick_dim(), pick_dim(), pick_width());
            steady_sender = ($urandom_range(0, 3) == 0);
            w  = active_width();
            nr = active_dim(cfg_rows);
            nc = active_dim(cfg_cols);
            for (int i = 0; i < w * w; i++)
                write_tap(i, pick_coef(w));
            repeat ($urandom_range(40, 120))
            begin
                if (useful_items - start >= RANDOM_ITEMS)
                    break;
                r   = $urandom_range(0, 99);
                raw = $urandom();
                if (r < 12)
                    write_tap($urandom_range(0, w * w - 1), pick_coef(w));
                else if (r < 16)
                    write_tap($urandom_range(0, 127), pick_coef(w));
                else if (r < 45)
                begin
                    if (r < 40)
                        store_at(8'($urandom_range(0, nr - 1)), 8'($urandom_range(0, nc - 1)),
                                 raw[23:0]);
                    else
                        store_at(raw[31:24], raw[7:0], {raw[15:8], raw[23:8]});
                end
                else if (r < 95)
                begin
                    if (r < 88)
                        compute_at(8'($urandom_range(0, nr - 1)), 8'($urandom_range(0, nc - 1)));
                    else
                        compute_at(raw[7:0], raw[15:8]);
                end
                else
                    send_unknown();
            end
        end
        steady_sender = 1'b0;
    endtask

    // Ready side of the result channel: random stalls, quiet stretches and the long hold
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (mode_left == 0)
            begin
                rsp_steady = ($urandom_range(0, 3) == 0);
                mode_left  = $urandom_range(50, 300);
            end
            mode_left--;
            if (holds_done != hold_requests)
            begin
                holds_done++;
                stall_left = HOLD_CYCLES;
            end
            else if (stall_left == 0 && !rsp_steady && $urandom_range(0, 2) == 0)
                stall_left = idle_len();
            if (stall_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // Check each result transaction against the oldest expected pixel
    always @(negedge clk)
    begin
        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (pending_pixels.size() == 0)
            begin
                $error("result with no pending compute: r=%0d g=%0d b=%0d a=%0d",
                       rsp_ch.red_out, rsp_ch.green_out, rsp_ch.blue_out, rsp_ch.alpha_out);
                mismatches++;
            end
            else
            begin
                oldest = pending_pixels.pop_front();
                if (rsp_ch.red_out !== oldest.red)
                begin
                    $error("red_out: expected %0d, got %0d", oldest.red, rsp_ch.red_out);
                    mismatches++;
                end
                if (rsp_ch.green_out !== oldest.green)
                begin
                    $error("green_out: expected %0d, got %0d", oldest.green, rsp_ch.green_out);
                    mismatches++;
                end
                if (rsp_ch.blue_out !== oldest.blue)
                begin
                    $error("blue_out: expected %0d, got %0d", oldest.blue, rsp_ch.blue_out);
                    mismatches++;
                end
                if (rsp_ch.alpha_out !== oldest.alpha)
                begin
                    $error("alpha_out: expected %0d, got %0d", oldest.alpha, rsp_ch.alpha_out);
                    mismatches++;
                end
                pixels_checked++;
            end
        end
    end

    // Hard stop if the run hangs
    initial
    begin
        #(TIMEOUT_NS);
        $display("Run timed out with %0d pixels still pending", pending_pixels.size());
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        req_ch.valid      = 1'b0;
        req_ch.cmd        = CMD_NONE;
        req_ch.row        = '0;
        req_ch.col        = '0;
        req_ch.coef_index = '0;
        req_ch.coef_value = '0;
        req_ch.red_in     = '0;
        req_ch.green_in   = '0;
        req_ch.blue_in    = '0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        cfg_rows          = 9'd256;
        cfg_cols          = 9'd256;
        cfg_width         = 4'd1;
        for (int i = 0; i < TAP_COUNT; i++)
            tap_table[i] = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_special_cases();
        test_output_backpressure();
        test_random_traffic();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d commands: %0d filtered pixels checked, %0d stores, %0d tap writes",
                 useful_items, pixels_checked, stores_sent, taps_sent);
        $display("Used %0d register writes across image sizes and widths, one long output hold",
                 reg_writes);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
